// File: design/lprd_pkg.sv
// Shared types and constants for the length-prefixed record deframer.
// Has no dependencies; used by length_prefixed_record_deframer.
package lprd_pkg;

   localparam int MAGIC_BYTES_DEFAULT  = 10;
   localparam int LENGTH_BYTES_DEFAULT = 4;

   // Expected stream magic, ASCII, zero padded past the tenth byte.
   localparam logic [7:0] MAGIC_TABLE [16] = '{
      8'h53, 8'h49, 8'h4D, 8'h50, 8'h4C, 8'h45, 8'h50, 8'h45,
      8'h52, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [2:0] {
      PH_MAGIC    = 3'd0,
      PH_VERSION  = 3'd1,
      PH_LENGTH   = 3'd2,
      PH_PAYLOAD  = 3'd3,
      PH_FINISHED = 3'd4,
      PH_ERROR    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_HEADER  = 3'd0,
      ST_PAYLOAD = 3'd1,
      ST_END     = 3'd2,
      ST_IGNORED = 3'd3,
      ST_ERROR   = 3'd4,
      ST_EOF_OK  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_MAGIC   = 2'd1,
      ERR_VERSION = 2'd2,
      ERR_TRUNC   = 2'd3
   } error_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_EOF  = 1'b1
   } opcode_type;

   localparam logic [15:0] SUPPORTED_VERSION = 16'd1;

endpackage

// File: design/length_prefixed_record_deframer.sv
// Length-prefixed record deframer: the single module of the block.
// Depends on lprd_pkg for phase, status and error codes and the magic table.

// The block takes one stream byte (or an end-of-file marker) per cycle and
// answers every transfer with exactly one registered result. A stream is a
// magic, a 2-byte little-endian version that must be 1, and then records of
// a little-endian length followed by that many payload bytes; payload bytes
// come out with record_last on the final one. A zero length ends the stream
// and later bytes are reported as ignored. Bad magic or version is sticky
// until reset. An end-of-file marker before the end of stream reports
// truncation (the sticky error if set) and leaves the parse state alone.
// Throughput is one item per cycle: the whole parse step is one pass of
// logic from the input port into the state and result registers, and the
// input stays ready while the result register is empty or being drained.
module length_prefixed_record_deframer
   import lprd_pkg::*;
#(
   parameter int MAGIC_BYTES  = MAGIC_BYTES_DEFAULT,
   parameter int LENGTH_BYTES = LENGTH_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_record_last,
   output logic [1:0] rsp_error_code
);

   localparam logic [4:0] MAGIC_COUNT  = 5'(MAGIC_BYTES);
   localparam logic [4:0] LENGTH_COUNT = 5'(LENGTH_BYTES);

   phase_type   phase_ff, phase_in;
   logic [3:0]  header_position_ff, header_position_in;
   logic [7:0]  low_version_byte_ff, low_version_byte_in;
   logic [31:0] length_accumulator_ff, length_accumulator_in;
   logic [31:0] payload_remaining_ff, payload_remaining_in;
   error_type   sticky_error_ff, sticky_error_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_payload_byte_ff, rsp_payload_byte_in;
   logic        rsp_record_last_ff, rsp_record_last_in;
   error_type   rsp_error_code_ff, rsp_error_code_in;

   logic        req_transfer;
   logic [4:0]  position_next;
   logic [31:0] length_next;
   logic        payload_last;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_transfer = req_valid && req_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_record_last  = rsp_record_last_ff;
   assign rsp_error_code   = rsp_error_code_ff;

   assign position_next = {1'b0, header_position_ff} + 5'd1;
   assign payload_last  = (payload_remaining_ff <= 32'd1);

   // Length bytes past the fourth cannot fit; any nonzero one saturates.
   always_comb begin
      if (header_position_ff < 4'd4) begin
         length_next = length_accumulator_ff |
                       (32'(req_data_byte) << {header_position_ff[1:0], 3'b000});
      end else if (req_data_byte != 8'd0) begin
         length_next = '1;
      end else begin
         length_next = length_accumulator_ff;
      end
   end

   always_comb begin
      phase_in              = phase_ff;
      header_position_in    = header_position_ff;
      low_version_byte_in   = low_version_byte_ff;
      length_accumulator_in = length_accumulator_ff;
      payload_remaining_in  = payload_remaining_ff;
      sticky_error_in       = sticky_error_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_status_in         = rsp_status_ff;
      rsp_payload_byte_in   = rsp_payload_byte_ff;
      rsp_record_last_in    = rsp_record_last_ff;
      rsp_error_code_in     = rsp_error_code_ff;

      if (req_transfer) begin
         rsp_valid_in        = 1'b1;
         rsp_status_in       = ST_HEADER;
         rsp_payload_byte_in = 8'd0;
         rsp_record_last_in  = 1'b0;
         rsp_error_code_in   = ERR_NONE;

         if (req_opcode == OP_EOF) begin
            case (phase_ff)
               PH_ERROR: begin
                  rsp_status_in     = ST_ERROR;
                  rsp_error_code_in = sticky_error_ff;
               end
               PH_MAGIC, PH_VERSION, PH_LENGTH, PH_PAYLOAD: begin
                  rsp_status_in     = ST_ERROR;
                  rsp_error_code_in = ERR_TRUNC;
               end
               default: begin
                  rsp_status_in = ST_EOF_OK;
               end
            endcase
         end else begin
            case (phase_ff)
               PH_MAGIC: begin
                  if (req_data_byte != MAGIC_TABLE[header_position_ff]) begin
                     phase_in          = PH_ERROR;
                     sticky_error_in   = ERR_MAGIC;
                     rsp_status_in     = ST_ERROR;
                     rsp_error_code_in = ERR_MAGIC;
                  end else if (position_next >= MAGIC_COUNT) begin
                     header_position_in = 4'd0;
                     phase_in           = PH_VERSION;
                  end else begin
                     header_position_in = position_next[3:0];
                  end
               end
               PH_VERSION: begin
                  if (header_position_ff == 4'd0) begin
                     low_version_byte_in = req_data_byte;
                     header_position_in  = 4'd1;
                  end else begin
                     header_position_in = 4'd0;
                     if ({req_data_byte, low_version_byte_ff} != SUPPORTED_VERSION) begin
                        phase_in          = PH_ERROR;
                        sticky_error_in   = ERR_VERSION;
                        rsp_status_in     = ST_ERROR;
                        rsp_error_code_in = ERR_VERSION;
                     end else begin
                        phase_in              = PH_LENGTH;
                        length_accumulator_in = 32'd0;
                     end
                  end
               end
               PH_LENGTH: begin
                  if (position_next >= LENGTH_COUNT) begin
                     header_position_in = 4'd0;
                     if (length_next == 32'd0) begin
                        length_accumulator_in = length_next;
                        phase_in              = PH_FINISHED;
                        rsp_status_in         = ST_END;
                     end else begin
                        payload_remaining_in  = length_next;
                        length_accumulator_in = 32'd0;
                        phase_in              = PH_PAYLOAD;
                     end
                  end else begin
                     header_position_in    = position_next[3:0];
                     length_accumulator_in = length_next;
                  end
               end
               PH_PAYLOAD: begin
                  rsp_status_in       = ST_PAYLOAD;
                  rsp_payload_byte_in = req_data_byte;
                  rsp_record_last_in  = payload_last;
                  if (payload_last) begin
                     payload_remaining_in  = 32'd0;
                     phase_in              = PH_LENGTH;
                     header_position_in    = 4'd0;
                     length_accumulator_in = 32'd0;
                  end else begin
                     payload_remaining_in = payload_remaining_ff - 32'd1;
                  end
               end
               PH_ERROR: begin
                  rsp_status_in     = ST_ERROR;
                  rsp_error_code_in = sticky_error_ff;
               end
               default: begin
                  rsp_status_in = ST_IGNORED;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_MAGIC;
         header_position_ff <= 4'd0;
         sticky_error_ff    <= ERR_NONE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         header_position_ff <= header_position_in;
         sticky_error_ff    <= sticky_error_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_version_byte_ff   <= low_version_byte_in;
      length_accumulator_ff <= length_accumulator_in;
      payload_remaining_ff  <= payload_remaining_in;
      rsp_status_ff         <= rsp_status_in;
      rsp_payload_byte_ff   <= rsp_payload_byte_in;
      rsp_record_last_ff    <= rsp_record_last_in;
      rsp_error_code_ff     <= rsp_error_code_in;
   end

`ifndef SYNTHESIS
   a_error_phase_has_code: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |-> (sticky_error_ff != ERR_NONE))
      else $error("error phase without a sticky error code");

   a_payload_phase_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (payload_remaining_ff != 32'd0))
      else $error("payload phase with no bytes remaining");

   a_magic_position_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MAGIC) |-> ({1'b0, header_position_ff} < MAGIC_COUNT))
      else $error("magic position beyond magic length");

   a_last_only_on_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_record_last_ff) |-> (rsp_status_ff == ST_PAYLOAD))
      else $error("record_last on a non-payload result");

   a_payload_passes_byte: assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_opcode == OP_DATA && phase_ff == PH_PAYLOAD) |=>
      (rsp_valid_ff && rsp_status_ff == ST_PAYLOAD &&
       rsp_payload_byte_ff == $past(req_data_byte)))
      else $error("payload byte not passed to the result");
`endif

endmodule

// File: tb/length_prefixed_record_deframer_tb.sv
// Self-checking testbench for length_prefixed_record_deframer: one stream with records,
// truncation markers, stalls on both sides, the end marker and trailing input.
// Depends on lprd_pkg and length_prefixed_record_deframer.
`timescale 1ns / 1ps

module length_prefixed_record_deframer_tb;
   import lprd_pkg::*;

   typedef struct packed {
      opcode_type op;
      logic [7:0] data;
   } stream_item_type;

   typedef struct packed {
      status_type status;
      logic [7:0] payload_byte;
      logic       record_last;
      error_type  error_code;
   } deframer_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_opcode = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_payload_byte;
   logic       rsp_record_last;
   logic [1:0] rsp_error_code;

   stream_item_type     pending_items[$];
   deframer_result_type expected_results[$];
   deframer_result_type oldest;
   stream_item_type     next_item;
   int                  mismatch_count = 0;
   int                  items_queued = 0;
   logic                steady_run = 1'b0;
   int                  hold_requests = 0;
   int                  holds_started = 0;
   int                  hold_left = 0;

   // Predicted parser state.
   phase_type   parse_phase = PH_MAGIC;
   logic [3:0]  hdr_index = 4'd0;
   logic [7:0]  version_lo = 8'h00;
   logic [31:0] length_sum = 32'd0;
   logic [31:0] payload_left = 32'd0;
   error_type   sticky_code = ERR_NONE;

   length_prefixed_record_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_record_last(rsp_record_last),
      .rsp_error_code(rsp_error_code)
   );

   always #5 clock = ~clock;

   function automatic deframer_result_type deframe_step(opcode_type op, logic [7:0] b);
      deframer_result_type r;
      r = '{status: ST_HEADER, payload_byte: 8'h00, record_last: 1'b0, error_code: ERR_NONE};
      if (op == OP_EOF) begin
         // An end-of-file marker never changes the parse state.
         if (parse_phase == PH_ERROR) begin
            r.status = ST_ERROR;
            r.error_code = sticky_code;
         end else if (parse_phase == PH_MAGIC || parse_phase == PH_VERSION ||
                      parse_phase == PH_LENGTH || parse_phase == PH_PAYLOAD) begin
            r.status = ST_ERROR;
            r.error_code = ERR_TRUNC;
         end else begin
            r.status = ST_EOF_OK;
         end
         return r;
      end
      case (parse_phase)
         PH_MAGIC: begin
            if (b != MAGIC_TABLE[hdr_index]) begin
               sticky_code = ERR_MAGIC;
               parse_phase = PH_ERROR;
               r.status = ST_ERROR;
               r.error_code = ERR_MAGIC;
            end else if (hdr_index + 1 >= MAGIC_BYTES_DEFAULT) begin
               hdr_index = 4'd0;
               parse_phase = PH_VERSION;
            end else begin
               hdr_index = hdr_index + 4'd1;
            end
         end
         PH_VERSION: begin
            if (hdr_index == 4'd0) begin
               version_lo = b;
               hdr_index = 4'd1;
            end else begin
               hdr_index = 4'd0;
               if ({b, version_lo} != SUPPORTED_VERSION) begin
                  sticky_code = ERR_VERSION;
                  parse_phase = PH_ERROR;
                  r.status = ST_ERROR;
                  r.error_code = ERR_VERSION;
               end else begin
                  parse_phase = PH_LENGTH;
                  length_sum = 32'd0;
               end
            end
         end
         PH_LENGTH: begin
            // Bytes beyond the fourth can only saturate the length.
            if (hdr_index < 4)
               length_sum = length_sum | (32'(b) << (8 * hdr_index));
            else if (b != 8'h00)
               length_sum = 32'hFFFF_FFFF;
            if (hdr_index + 1 >= LENGTH_BYTES_DEFAULT) begin
               hdr_index = 4'd0;
               if (length_sum == 32'd0) begin
                  parse_phase = PH_FINISHED;
                  r.status = ST_END;
               end else begin
                  payload_left = length_sum;
                  length_sum = 32'd0;
                  parse_phase = PH_PAYLOAD;
               end
            end else begin
               hdr_index = hdr_index + 4'd1;
            end
         end
         PH_PAYLOAD: begin
            r.status = ST_PAYLOAD;
            r.payload_byte = b;
            r.record_last = (payload_left <= 32'd1);
            payload_left = payload_left - 32'd1;
            if (r.record_last) begin
               payload_left = 32'd0;
               parse_phase = PH_LENGTH;
               hdr_index = 4'd0;
               length_sum = 32'd0;
            end
         end
         PH_ERROR: begin
            r.status = ST_ERROR;
            r.error_code = sticky_code;
         end
         default: r.status = ST_IGNORED;
      endcase
      return r;
   endfunction

   // Driver: offers the next pending item, idling at random unless in a steady run.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() != 0 && (steady_run || $urandom_range(0, 99) >= 21)) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_opcode <= next_item.op;
            req_data_byte <= next_item.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random backpressure, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_requests > holds_started) begin
         holds_started <= holds_started + 1;
         hold_left <= 80;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_run || $urandom_range(0, 99) >= 21;
      end
   end

   // Monitor: predicts each input transfer and checks each result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(deframe_step(opcode_type'(req_opcode), req_data_byte));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer: status %0d", rsp_status);
               mismatch_count++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_status != oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_payload_byte != oldest.payload_byte) begin
                  $error("payload_byte: expected %0d, actual %0d",
                         oldest.payload_byte, rsp_payload_byte);
                  mismatch_count++;
               end
               if (rsp_record_last != oldest.record_last) begin
                  $error("record_last: expected %0d, actual %0d",
                         oldest.record_last, rsp_record_last);
                  mismatch_count++;
               end
               if (rsp_error_code != oldest.error_code) begin
                  $error("error_code: expected %0d, actual %0d",
                         oldest.error_code, rsp_error_code);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic queue_byte(logic [7:0] b);
      pending_items.push_back('{op: OP_DATA, data: b});
      items_queued++;
   endtask

   task automatic queue_eof();
      pending_items.push_back('{op: OP_EOF, data: 8'($urandom_range(0, 255))});
      items_queued++;
   endtask

   // A data byte, sometimes followed by an early end-of-file marker.
   task automatic queue_noisy(logic [7:0] b);
      queue_byte(b);
      if ($urandom_range(0, 99) < 3)
         queue_eof();
   endtask

   task automatic queue_record(int unsigned len);
      logic [31:0] len_bits;
      len_bits = len;
      for (int i = 0; i < 4; i++)
         queue_noisy(len_bits[8 * i +: 8]);
      for (int unsigned i = 0; i < len; i++)
         queue_noisy(8'($urandom_range(0, 255)));
   endtask

   task automatic queue_random_records(int count);
      int stop_at;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            queue_record($urandom_range(13, 60));
         else
            queue_record($urandom_range(1, 12));
      end
   endtask

   task automatic wait_for_drain();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: truncation in the magic and version phases, then the shortest records.
      queue_eof();
      for (int i = 0; i < MAGIC_BYTES_DEFAULT; i++) begin
         if (i == 5)
            queue_eof();
         queue_byte(MAGIC_TABLE[i]);
      end
      queue_byte(8'h01);
      queue_eof();
      queue_byte(8'h00);
      queue_record(0 + 1);
      queue_record(2);
      wait_for_drain();

      // The receiver holds off long enough for the block to stall its input.
      hold_requests++;
      queue_record(30);
      wait_for_drain();

      queue_random_records(120);
      wait_for_drain();

      steady_run = 1'b1;
      queue_random_records(150);
      wait_for_drain();
      steady_run = 1'b0;

      // One long record whose length uses the second length byte.
      queue_record(256);
      queue_random_records(120);

      // End marker, then bytes and end-of-file markers after the end.
      for (int i = 0; i < 4; i++)
         queue_byte(8'h00);
      for (int i = 0; i < 20; i++) begin
         if ($urandom_range(0, 3) == 0)
            queue_eof();
         else
            queue_byte(8'($urandom_range(0, 255)));
      end
      queue_eof();
      wait_for_drain();
      repeat (10) @(negedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("length_prefixed_record_deframer_tb: PASS");
      else
         $display("length_prefixed_record_deframer_tb: FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("length_prefixed_record_deframer_tb: FAIL");
      $finish;
   end

endmodule

// File: sim.f
design/lprd_pkg.sv
design/length_prefixed_record_deframer.sv
tb/length_prefixed_record_deframer_tb.sv
